FILE: sv/assert_macros.svh
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent, checked outside reset.
`define BLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle, checked outside reset.
`define BLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ble_pkg.sv
// Types and constants of the bounded list engine.
package ble_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int ACTION_W      = 4;
  localparam int POS_W         = 7;
  localparam int DATA_W        = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 4'd0,
    ACT_INS_BACK  = 4'd1,
    ACT_INS_AT    = 4'd2,
    ACT_REM_FRONT = 4'd3,
    ACT_REM_BACK  = 4'd4,
    ACT_REM_AT    = 4'd5,
    ACT_SEARCH    = 4'd6,
    ACT_SELECT    = 4'd7,
    ACT_REPLACE   = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_PUT,
    ST_SCAN,
    ST_SEL_GET,
    ST_DONE
  } state_t;

endpackage

FILE: sv/ble_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bounded_list_engine_top.sv
// Bounded ordered list engine: sequencer over one entry RAM.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, action, position,     | in
//          | data_value                                |
//  out     | out_valid, out_ready, ok, read_value,     | out
//          | found_position, entry_count, is_empty,    |
//          | is_full                                   |
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Insert and remove shift one entry per cycle through the RAM (one read, one write port);
// an append, or a removal of the last entry, shifts nothing. Search streams one entry per cycle.
// A result beat may wait on out_ready; the next request is taken meanwhile.
// rst clears the count and control state; entry RAM is not cleared.
`include "assert_macros.svh"

module bounded_list_engine_top
  import ble_pkg::*;
#(
  parameter int CAPACITY_MAX = CAPACITY_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] data_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [DATA_W-1:0] read_value,
  output logic [POS_W-1:0]  found_position,
  output logic [POS_W-1:0]  entry_count,
  output logic              is_empty,
  output logic              is_full
);

  localparam int AW = $clog2(CAPACITY_MAX);
  localparam int CW = $clog2(CAPACITY_MAX + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  state_t state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        src, src_next;
  logic [AW-1:0]        last, last_next;
  logic [AW-1:0]        pend_addr, pend_addr_next;
  logic [AW-1:0]        put_addr, put_addr_next;
  logic                 pend, pend_next;
  logic                 active, active_next;
  logic                 grow, grow_next;
  logic [WORD_BITS-1:0] val_q, val_next;
  logic                 res_ok, res_ok_next;
  logic [DATA_W-1:0]    res_rd, res_rd_next;
  logic [CW-1:0]        res_found, res_found_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] word_in;
  logic [XW-1:0]        cnt_x, pos_x, cnt_m1x, ins_pos, rem_pos;
  logic [CW-1:0]        cnt_m1;
  logic                 ins_ok, rem_ok, pos_in_range, out_load;

  ble_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(CAPACITY_MAX)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign word_in      = WORD_BITS'(data_value);
  assign cnt_x        = XW'(count);
  assign pos_x        = XW'(position);
  assign cnt_m1       = count - CW'(1);
  assign cnt_m1x      = cnt_x - XW'(1);
  assign pos_in_range = (pos_x < cnt_x);
  assign out_load     = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    case (action_t'(action))
      ACT_INS_FRONT: ins_pos = '0;
      ACT_INS_BACK:  ins_pos = cnt_x;
      default:       ins_pos = pos_x;
    endcase
    case (action_t'(action))
      ACT_REM_FRONT: rem_pos = '0;
      ACT_REM_BACK:  rem_pos = cnt_m1x;
      default:       rem_pos = pos_x;
    endcase
  end

  assign ins_ok = (count != CW'(CAPACITY_MAX)) && (ins_pos <= cnt_x);
  assign rem_ok = (count != '0) && (rem_pos < cnt_x);

  always_comb begin
    state_next     = state;
    count_next     = count;
    src_next       = src;
    last_next      = last;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    put_addr_next  = put_addr;
    active_next    = active;
    grow_next      = grow;
    val_next       = val_q;
    res_ok_next    = res_ok;
    res_rd_next    = res_rd;
    res_found_next = res_found;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr;
    ram_wdata      = ram_rdata;
    ram_raddr      = src;
    in_ready       = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          val_next       = word_in;
          res_ok_next    = 1'b0;
          res_rd_next    = '0;
          res_found_next = '0;
          pend_next      = 1'b0;
          active_next    = 1'b0;
          state_next     = ST_DONE;
          case (action_t'(action))
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
              if (ins_ok) begin
                res_ok_next   = 1'b1;
                put_addr_next = ins_pos[AW-1:0];
                if (ins_pos == cnt_x) begin
                  state_next = ST_PUT;
                end else begin
                  src_next    = cnt_m1[AW-1:0];
                  last_next   = ins_pos[AW-1:0];
                  grow_next   = 1'b1;
                  active_next = 1'b1;
                  state_next  = ST_MOVE;
                end
              end
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
              if (rem_ok) begin
                res_ok_next = 1'b1;
                if (rem_pos == cnt_m1x) begin
                  count_next = cnt_m1;
                end else begin
                  src_next    = rem_pos[AW-1:0] + AW'(1);
                  last_next   = cnt_m1[AW-1:0];
                  grow_next   = 1'b0;
                  active_next = 1'b1;
                  state_next  = ST_MOVE;
                end
              end
            end
            ACT_SEARCH: begin
              res_ok_next    = 1'b1;
              res_found_next = count;
              if (count != '0) begin
                src_next    = '0;
                last_next   = cnt_m1[AW-1:0];
                active_next = 1'b1;
                state_next  = ST_SCAN;
              end
            end
            ACT_SELECT: begin
              if (count != '0) begin
                ram_raddr   = pos_in_range ? pos_x[AW-1:0] : cnt_m1[AW-1:0];
                res_ok_next = pos_in_range;
                state_next  = ST_SEL_GET;
              end
            end
            ACT_REPLACE: begin
              if (pos_in_range) begin
                ram_we      = 1'b1;
                ram_waddr   = pos_x[AW-1:0];
                ram_wdata   = word_in;
                res_ok_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE: begin
        ram_we = pend;
        if (active) begin
          ram_raddr      = src;
          pend_next      = 1'b1;
          pend_addr_next = grow ? src + AW'(1) : src - AW'(1);
          if (src == last) begin
            active_next = 1'b0;
          end else begin
            src_next = grow ? src - AW'(1) : src + AW'(1);
          end
        end else begin
          pend_next = 1'b0;
          if (grow) begin
            state_next = ST_PUT;
          end else begin
            count_next = cnt_m1;
            state_next = ST_DONE;
          end
        end
      end
      ST_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = put_addr;
        ram_wdata  = val_q;
        count_next = count + CW'(1);
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (pend && (ram_rdata == val_q)) begin
          res_found_next = CW'(pend_addr);
          pend_next      = 1'b0;
          active_next    = 1'b0;
          state_next     = ST_DONE;
        end else if (active) begin
          ram_raddr      = src;
          pend_next      = 1'b1;
          pend_addr_next = src;
          if (src == last) begin
            active_next = 1'b0;
          end else begin
            src_next = src + AW'(1);
          end
        end else begin
          pend_next  = 1'b0;
          state_next = ST_DONE;
        end
      end
      ST_SEL_GET: begin
        res_rd_next = DATA_W'(ram_rdata);
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      active <= active_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src       <= src_next;
    last      <= last_next;
    pend_addr <= pend_addr_next;
    put_addr  <= put_addr_next;
    grow      <= grow_next;
    val_q     <= val_next;
    res_ok    <= res_ok_next;
    res_rd    <= res_rd_next;
    res_found <= res_found_next;
    if (out_load) begin
      ok             <= res_ok;
      read_value     <= res_rd;
      found_position <= POS_W'(res_found);
      entry_count    <= POS_W'(count);
      is_empty       <= (count == '0);
      is_full        <= (count == CW'(CAPACITY_MAX));
    end
  end

  `BLE_ASSERT(a_count_bound, count <= CW'(CAPACITY_MAX), "count beyond capacity")
  `BLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
  `BLE_ASSERT_NEXT(a_idle_count_stable, in_ready && !in_valid, $stable(count), "count moved while idle")
  `BLE_ASSERT_IMPL(a_no_write_on_read, ram_we, state != ST_SCAN && state != ST_SEL_GET, "RAM write during read-only action")

endmodule
